// ===== design/bbc_pkg.sv =====
`timescale 1ns / 1ps

package bbc_pkg;

  // Stack sizing
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int LEFT_W      = 7;
  localparam int LEFT_MAX    = 127;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_EXCESS   = 3'd2;
  localparam logic [2:0] ST_UNCLOSED = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // Bracket kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;
  localparam kind_t KIND_NONE   = 2'd3;

  // Bracket characters
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Stack memory access
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    kind_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } stack_req_t;

  // One result
  typedef struct packed {
    logic [2:0]        status;
    logic [LEFT_W-1:0] open_left;
  } result_t;

  function automatic kind_t open_kind(input logic [7:0] ch);
    kind_t k;
    unique case (ch)
      CH_LPAREN: k = KIND_ROUND;
      CH_LBRACK: k = KIND_SQUARE;
      CH_LBRACE: k = KIND_CURLY;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t close_kind(input logic [7:0] ch);
    kind_t k;
    unique case (ch)
      CH_RPAREN: k = KIND_ROUND;
      CH_RBRACK: k = KIND_SQUARE;
      CH_RBRACE: k = KIND_CURLY;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [LEFT_W-1:0] sat_left(input logic [LVL_W-1:0] lvl);
    logic [LEFT_W-1:0] r;
    if (32'(lvl) > 32'(LEFT_MAX)) begin
      r = LEFT_W'(LEFT_MAX);
    end else begin
      r = LEFT_W'(lvl);
    end
    return r;
  endfunction

endpackage

// ===== design/bbc_stack_ram.sv =====
`timescale 1ns / 1ps

module bbc_stack_ram
  import bbc_pkg::*;
(
  input  logic       clk,
  input  stack_req_t req,
  output kind_t      rdata
);

  kind_t mem [STACK_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== design/bbc_out_queue.sv =====
`timescale 1ns / 1ps

module bbc_out_queue
  import bbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  result_t    push_data,
  output logic [1:0] count,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    head
);

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic       pop;

  assign result_valid = (count != 2'd0);
  assign pop          = result_valid && result_ready;
  assign head         = slots[rd_ptr];

  // Store incoming result
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== design/bracket_balance_checker_unit.sv =====
`timescale 1ns / 1ps
// result_valid rises once the end-of-string byte has passed the stage-two registers
// and its result has been written into the result queue.
// One byte per cycle is accepted while char_ready is high. The stack read for a close
// bracket is registered behind the push/pop decision; stage two compares the kinds.
// A two-entry result queue absorbs output stalls before the input is held off.
// Reset (rst, synchronous): stack level, error latch, pipeline and queue clear.

module bracket_balance_checker_unit
  import bbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  char_in,
  input  logic        end_of_string,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  status,
  output logic [6:0]  open_left
);

  // Stage one state
  logic [LVL_W-1:0] level;
  logic [LVL_W-1:0] level_next;
  logic [2:0]       error_latch;
  logic [2:0]       error_latch_next;

  // Stage two registers
  logic             s2_valid;
  logic             s2_end;
  logic             s2_pop;
  kind_t            s2_kind;
  logic [2:0]       s2_err;
  logic [LVL_W-1:0] s2_level;

  logic             xfer;
  kind_t            okind;
  kind_t            ckind;
  kind_t            rdata;
  logic             mismatch;
  logic [2:0]       eff_err;
  logic             is_open;
  logic             is_close;
  logic             full;
  logic             empty;
  logic             do_push;
  logic             do_pop;
  logic [2:0]       new_err;
  logic [LVL_W-1:0] level_op;
  logic [LVL_W-1:0] level_dec;
  stack_req_t       req;
  logic [1:0]       q_count;
  logic             q_push;
  result_t          q_data;
  result_t          q_head;
  logic [2:0]       q_load;

  // Hold input while result queue could fill; a result leaving this cycle frees a slot
  assign q_load     = {1'b0, q_count} + {2'b00, (s2_valid && s2_end)};
  assign char_ready = (q_load < (3'd2 + {2'b00, (result_valid && result_ready)}));
  assign xfer       = char_valid && char_ready;

  // Classify the byte and fold in a pending mismatch
  assign okind     = open_kind(char_in);
  assign ckind     = close_kind(char_in);
  assign mismatch  = s2_valid && s2_pop && (rdata != s2_kind);
  assign is_open   = (okind != KIND_NONE);
  assign is_close  = (ckind != KIND_NONE);
  assign full      = (level == LVL_W'(STACK_DEPTH));
  assign empty     = (level == '0);
  assign level_dec = level - LVL_W'(1);

  always_comb begin
    priority if (error_latch != ST_OK) begin
      eff_err = error_latch;
    end else if (mismatch && !s2_end) begin
      eff_err = ST_MISMATCH;
    end else begin
      eff_err = ST_OK;
    end
  end

  // Decide push, pop or error
  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    new_err  = eff_err;
    level_op = level;
    if (xfer && (eff_err == ST_OK)) begin
      priority if (is_open) begin
        if (full) begin
          new_err = ST_OVERFLOW;
        end else begin
          do_push  = 1'b1;
          level_op = level + LVL_W'(1);
        end
      end else if (is_close) begin
        if (empty) begin
          new_err = ST_EXCESS;
        end else begin
          do_pop   = 1'b1;
          level_op = level_dec;
        end
      end else begin
        new_err = ST_OK;
      end
    end
  end

  // Clear for the next string after the last byte
  always_comb begin
    priority if (xfer && end_of_string) begin
      level_next       = '0;
      error_latch_next = ST_OK;
    end else if (xfer) begin
      level_next       = level_op;
      error_latch_next = new_err;
    end else begin
      level_next       = level;
      error_latch_next = eff_err;
    end
  end

  // Stack memory requests
  always_comb begin
    req.we    = do_push;
    req.waddr = level[ADDR_W-1:0];
    req.wdata = okind;
    req.re    = do_pop;
    req.raddr = level_dec[ADDR_W-1:0];
  end

  bbc_stack_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Stage one control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level       <= '0;
      error_latch <= ST_OK;
      s2_valid    <= 1'b0;
    end else begin
      level       <= level_next;
      error_latch <= error_latch_next;
      s2_valid    <= xfer;
    end
  end

  // Stage two payload
  always_ff @(posedge clk) begin
    if (xfer) begin
      s2_end   <= end_of_string;
      s2_pop   <= do_pop;
      s2_kind  <= ckind;
      s2_err   <= new_err;
      s2_level <= level_op;
    end
  end

  // Form final status
  assign q_push = s2_valid && s2_end;
  always_comb begin
    priority if (s2_err != ST_OK) begin
      q_data.status = s2_err;
    end else if (mismatch) begin
      q_data.status = ST_MISMATCH;
    end else if (s2_level != '0) begin
      q_data.status = ST_UNCLOSED;
    end else begin
      q_data.status = ST_OK;
    end
    q_data.open_left = sat_left(s2_level);
  end

  bbc_out_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (q_push),
    .push_data    (q_data),
    .count        (q_count),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .head         (q_head)
  );

  assign status    = q_head.status;
  assign open_left = q_head.open_left;

  // Checks
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(STACK_DEPTH))
    else $error("stack level above depth");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    xfer && end_of_string |=> (level == '0) && (error_latch == ST_OK))
    else $error("state not cleared after last byte");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count != 2'd2) || result_ready)
    else $error("result queue overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    do_pop |=> s2_pop && s2_valid)
    else $error("pop lost in pipeline");

endmodule
